### rtl/assert_macros.svh
// assertion macros shared by the rtl files
// expects clk and arst_n in the scope of the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define NSP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NSP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nsp_pkg.sv
// types, sizes and register codes of the nat syn port allocator
// no dependencies
package nsp_pkg;

	localparam int BUCKET_BITS = 14;
	localparam int BUCKETS     = 1 << BUCKET_BITS;
	localparam int SLOTS       = 6;
	localparam int POOL_BITS   = 16;
	localparam int POOL        = 1 << POOL_BITS;

	localparam int FILL_W     = $clog2(SLOTS + 1);
	localparam int ENTRY_BITS = $clog2(BUCKETS * SLOTS);
	localparam int CLR_BITS   = (POOL_BITS > BUCKET_BITS) ? POOL_BITS : BUCKET_BITS;

	localparam int ADDR_W   = 32;
	localparam int PORT_W   = 16;
	localparam int HASH_W   = 32;
	localparam int PREFIX_W = 24;
	localparam int BNUM_W   = 14;
	localparam int SLOT_W   = 3;
	localparam int ENTRY_W  = 64;
	localparam int RMAP_W   = 49;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [ADDR_W-1:0]   PUBLIC_ADDRESS_RST = '0;
	localparam logic [PORT_W-1:0]   FIRST_PORT_RST     = '0;
	localparam logic [PREFIX_W-1:0] LAN_PREFIX_RST     = 24'hC0A801;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PUBLIC_ADDRESS    = 2'd0,
		REG_FIRST_PUBLIC_PORT = 2'd1,
		REG_LAN_PREFIX        = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] source_address;
		logic [PORT_W-1:0] source_port;
		logic [HASH_W-1:0] flow_hash;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] new_address;
		logic [PORT_W-1:0] new_port;
		logic              translated;
		logic              bucket_full;
		logic [BNUM_W-1:0] bucket_number;
		logic [SLOT_W-1:0] slot_used;
	} out_item_t;

	// table update issued by the compute stage
	typedef struct packed {
		logic                   fill_we;
		logic [BUCKET_BITS-1:0] bucket;
		logic [FILL_W-1:0]      fill;
		logic                   entry_we;
		logic [ENTRY_BITS-1:0]  entry_idx;
		logic [ENTRY_W-1:0]     entry_data;
		logic                   rmap_we;
		logic [POOL_BITS-1:0]   rmap_idx;
		logic [RMAP_W-1:0]      rmap_data;
	} upd_t;

endpackage

### rtl/nsp_tables.sv
// bucket fill counts, bucket entries and reverse map memories
// with the clearing pass after reset; uses nsp_pkg and assert_macros.svh
`include "assert_macros.svh"

module nsp_tables import nsp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [BUCKET_BITS-1:0] rd_bucket,
	output logic [FILL_W-1:0]      rd_fill,
	input  upd_t                   upd,
	output logic                   clr_done
);

	logic [FILL_W-1:0]  fill_mem  [BUCKETS];
	logic [ENTRY_W-1:0] entry_mem [BUCKETS * SLOTS];
	logic [RMAP_W-1:0]  rmap_mem  [POOL];

	logic [CLR_BITS-1:0] clr_cnt_q;
	logic                clr_done_q;
	logic [FILL_W-1:0]   rd_fill_q;

	logic                   fill_we_m;
	logic [BUCKET_BITS-1:0] fill_addr_m;
	logic [FILL_W-1:0]      fill_din_m;
	logic                   rmap_we_m;
	logic [POOL_BITS-1:0]   rmap_addr_m;
	logic [RMAP_W-1:0]      rmap_din_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == '1) begin
				clr_done_q <= 1'b1;
			end
		end
	end

	// the clearing pass owns the write ports until it ends
	always_comb begin
		if (!clr_done_q) begin
			fill_we_m   = 1'b1;
			fill_addr_m = clr_cnt_q[BUCKET_BITS-1:0];
			fill_din_m  = '0;
			rmap_we_m   = 1'b1;
			rmap_addr_m = clr_cnt_q[POOL_BITS-1:0];
			rmap_din_m  = '0;
		end else begin
			fill_we_m   = upd.fill_we;
			fill_addr_m = upd.bucket;
			fill_din_m  = upd.fill;
			rmap_we_m   = upd.rmap_we;
			rmap_addr_m = upd.rmap_idx;
			rmap_din_m  = upd.rmap_data;
		end
	end

	always_ff @(posedge clk) begin
		if (fill_we_m) begin
			fill_mem[fill_addr_m] <= fill_din_m;
		end
		if (rd_en) begin
			rd_fill_q <= fill_mem[rd_bucket];
		end
	end

	always_ff @(posedge clk) begin
		if (upd.entry_we && clr_done_q) begin
			entry_mem[upd.entry_idx] <= upd.entry_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rmap_we_m) begin
			rmap_mem[rmap_addr_m] <= rmap_din_m;
		end
	end

	assign rd_fill  = rd_fill_q;
	assign clr_done = clr_done_q;

	`NSP_ASSERT(a_no_read_while_clearing, rd_en |-> clr_done_q, "fill read during clearing pass")
	`NSP_ASSERT(a_no_update_while_clearing, (upd.fill_we || upd.rmap_we) |-> clr_done_q,
		"table update during clearing pass")
	`NSP_ASSERT(a_fill_bounded, (upd.fill_we && clr_done_q) |-> (upd.fill <= FILL_W'(SLOTS)),
		"bucket fill count beyond slot count")

endmodule

### rtl/nat_syn_port_allocator.sv
// source nat port allocation for tcp syn packets, top level
// uses nsp_pkg, nsp_tables and assert_macros.svh
//
//  channel  signals                         direction  moves
//  in       in_valid in_ready in_data       input      one syn packet item
//  out      out_valid out_ready out_data    output     one rewritten item
//  cfg      cfg_we cfg_index cfg_wdata      input      one register write
//
// the bucket fill count of each item is read from its memory in the accept
// cycle and written back with the result when the compute stage finishes.
// after reset a clearing pass zeroes fill counts and reverse map; no item
// is accepted until it ends.
// a result waiting at the output register stalls the compute stage; the
// next item is still accepted while the previous result waits.
`include "assert_macros.svh"

module nat_syn_port_allocator import nsp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [ADDR_W-1:0]   public_address_q;
	logic [PORT_W-1:0]   first_port_q;
	logic [PREFIX_W-1:0] lan_prefix_q;
	logic [PORT_W-1:0]   next_port_q;

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_q;
	logic      out_valid_q;

	logic                   clr_done;
	logic [FILL_W-1:0]      fill_rd;
	logic                   accept;
	logic                   done_s1;
	logic                   in_lan;
	logic                   full;
	logic [BUCKET_BITS-1:0] bucket;
	upd_t                   upd;
	out_item_t              res;

	assign in_ready = clr_done && !valid_s1;
	assign accept   = in_valid && in_ready;
	assign done_s1  = valid_s1 && (!out_valid_q || out_ready);

	nsp_tables u_tables (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_bucket (in_data.flow_hash[BUCKET_BITS-1:0]),
		.rd_fill   (fill_rd),
		.upd       (upd),
		.clr_done  (clr_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			public_address_q <= PUBLIC_ADDRESS_RST;
			first_port_q     <= FIRST_PORT_RST;
			lan_prefix_q     <= LAN_PREFIX_RST;
			next_port_q      <= FIRST_PORT_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PUBLIC_ADDRESS: begin
						public_address_q <= cfg_wdata[ADDR_W-1:0];
					end
					REG_FIRST_PUBLIC_PORT: begin
						first_port_q <= cfg_wdata[PORT_W-1:0];
					end
					REG_LAN_PREFIX: begin
						lan_prefix_q <= cfg_wdata[PREFIX_W-1:0];
					end
					default: begin
					end
				endcase
			end
			// writing the pool start restarts the counter
			if (cfg_we && cfg_index == REG_FIRST_PUBLIC_PORT) begin
				next_port_q <= cfg_wdata[PORT_W-1:0];
			end else if (done_s1 && in_lan) begin
				next_port_q <= next_port_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	assign in_lan = item_s1.source_address[ADDR_W-1:ADDR_W-PREFIX_W] == lan_prefix_q;
	assign bucket = item_s1.flow_hash[BUCKET_BITS-1:0];
	assign full   = fill_rd >= FILL_W'(SLOTS);

	always_comb begin
		upd.fill_we    = done_s1 && in_lan && !full;
		upd.bucket     = bucket;
		upd.fill       = fill_rd + 1'b1;
		upd.entry_we   = done_s1 && in_lan && !full;
		upd.entry_idx  = ENTRY_BITS'(bucket) * ENTRY_BITS'(SLOTS) + ENTRY_BITS'(fill_rd);
		upd.entry_data = {item_s1.source_address, item_s1.source_port, next_port_q};
		upd.rmap_we    = done_s1 && in_lan;
		upd.rmap_idx   = POOL_BITS'(next_port_q - first_port_q);
		upd.rmap_data  = {1'b1, item_s1.source_address, item_s1.source_port};
	end

	always_comb begin
		if (in_lan) begin
			res.new_address   = public_address_q;
			res.new_port      = next_port_q;
			res.translated    = 1'b1;
			res.bucket_full   = full;
			res.bucket_number = BNUM_W'(bucket);
			res.slot_used     = full ? '0 : SLOT_W'(fill_rd);
		end else begin
			res.new_address   = item_s1.source_address;
			res.new_port      = item_s1.source_port;
			res.translated    = 1'b0;
			res.bucket_full   = 1'b0;
			res.bucket_number = '0;
			res.slot_used     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`NSP_ASSERT(a_result_from_stage, $rose(out_valid_q) |-> $past(valid_s1),
		"result appeared without an item in the compute stage")
	`NSP_ASSERT(a_full_implies_translated, (out_valid_q && out_q.bucket_full) |->
		(out_q.translated && out_q.slot_used == '0), "bucket_full on untranslated item")
	`NSP_ASSERT(a_port_advance, (done_s1 && in_lan && !cfg_we) |=>
		(next_port_q == PORT_W'($past(next_port_q) + 1'b1)), "public port counter skipped")
	`NSP_ASSERT_ALWAYS(a_idle_in_reset, !arst_n |-> (!out_valid && !in_ready),
		"handshake active during reset")

endmodule
